/* design/gap_pkg.sv */
// Shared types and constants for the int8 global average pooling core.
`timescale 1ns / 1ps
package gap_pkg;

   localparam int SAMPLE_W      = 8;
   localparam int AVG_W         = 8;
   localparam int IDX_W         = 11;
   localparam int SPATIAL_REG_W = 13;
   localparam int CHANNEL_REG_W = 12;
   localparam int CSR_IDX_W     = 8;
   localparam int CSR_DATA_W    = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SPATIAL_SIZE  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 8'd1;

   localparam logic [SPATIAL_REG_W-1:0] SPATIAL_RESET = 13'd49;
   localparam logic [CHANNEL_REG_W-1:0] CHANNEL_RESET = 12'd1280;

   localparam logic signed [AVG_W-1:0] AVG_MAX   = 8'sd127;
   localparam logic signed [AVG_W-1:0] AVG_MIN   = -8'sd128;
   localparam logic [AVG_W-1:0]        POS_LIMIT = 8'd127;
   localparam logic [AVG_W-1:0]        NEG_LIMIT = 8'd128;

   // Quotient bits produced by the serial divider, one per cycle
   localparam int QUOT_W  = 8;
   localparam int STEP_W  = $clog2(QUOT_W);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } back_state_type;

endpackage

/* design/gap_front.sv */
// Front end: configuration registers, running sum and sample/channel counters.
`timescale 1ns / 1ps
module gap_front #(
   parameter int MAX_SPATIAL  = 4096,
   parameter int CHAN_LIMIT   = 2048,
   parameter int CNT_W        = 13,
   parameter int SUM_W        = 20,
   parameter int DATA_W       = 45
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gap_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gap_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [gap_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                 queue_full,
   output logic                                 push_valid,
   output logic [DATA_W-1:0]                    push_data
);
   import gap_pkg::*;

   localparam int CH_W  = (CHAN_LIMIT > 1) ? $clog2(CHAN_LIMIT) : 1;
   localparam int CHE_W = $clog2(CHAN_LIMIT + 1) + 1;

   logic [SPATIAL_REG_W-1:0] spatial_ff, spatial_in;
   logic [CHANNEL_REG_W-1:0] channels_ff, channels_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [CH_W-1:0]          ch_ff, ch_in;

   logic [31:0]             sp_raw, ch_raw, ch_wide;
   logic [CNT_W-1:0]        sp_eff, cnt_next;
   logic [CHE_W-1:0]        ch_eff, ch_next;
   logic signed [SUM_W-1:0] sum_next;
   logic                    accept, chan_end, map_end;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      spatial_in  = spatial_ff;
      channels_in = channels_ff;
      if (csr_valid && csr_ready) begin
         priority if (csr_index == CSR_SPATIAL_SIZE) begin
            spatial_in = csr_data[SPATIAL_REG_W-1:0];
         end else if (csr_index == CSR_CHANNEL_COUNT) begin
            channels_in = csr_data[CHANNEL_REG_W-1:0];
         end
      end
   end

   // Effective sizes: zero acts as one, oversize is clamped
   always_comb begin
      sp_raw = 32'(spatial_ff);
      ch_raw = 32'(channels_ff);
      if (sp_raw == 32'd0) sp_raw = 32'd1;
      else if (sp_raw > 32'(MAX_SPATIAL)) sp_raw = 32'(MAX_SPATIAL);
      if (ch_raw == 32'd0) ch_raw = 32'd1;
      else if (ch_raw > 32'(CHAN_LIMIT)) ch_raw = 32'(CHAN_LIMIT);
   end
   assign sp_eff = sp_raw[CNT_W-1:0];
   assign ch_eff = ch_raw[CHE_W-1:0];

   assign sum_next = sum_ff + SUM_W'(req_sample);
   assign cnt_next = cnt_ff + 1'b1;
   assign ch_next  = CHE_W'(ch_ff) + 1'b1;
   assign chan_end = cnt_next >= sp_eff;
   assign map_end  = ch_next >= ch_eff;
   assign ch_wide  = 32'(ch_ff);

   assign push_valid = accept && chan_end;
   assign push_data  = {sum_next, sp_eff, ch_wide[IDX_W-1:0], map_end};

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      ch_in  = ch_ff;
      if (accept) begin
         if (chan_end) begin
            sum_in = '0;
            cnt_in = '0;
            ch_in  = map_end ? '0 : ch_next[CH_W-1:0];
         end else begin
            sum_in = sum_next;
            cnt_in = cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spatial_ff  <= SPATIAL_RESET;
         channels_ff <= CHANNEL_RESET;
         sum_ff      <= '0;
         cnt_ff      <= '0;
         ch_ff       <= '0;
      end else begin
         spatial_ff  <= spatial_in;
         channels_ff <= channels_in;
         sum_ff      <= sum_in;
         cnt_ff      <= cnt_in;
         ch_ff       <= ch_in;
      end
   end

endmodule

/* design/gap_queue.sv */
// Short FIFO between the accumulating front end and the dividing back end.
`timescale 1ns / 1ps
module gap_queue #(
   parameter int DATA_W = 45
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output logic [DATA_W-1:0] head_data
);
   import gap_pkg::*;

   logic [DATA_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push_valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push_valid) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full || pop)
      else $error("transfer into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

/* design/gap_back.sv */
// Back end: rounding, bit-serial restoring division, saturation and result register.
`timescale 1ns / 1ps
module gap_back #(
   parameter int CNT_W  = 13,
   parameter int SUM_W  = 20,
   parameter int DATA_W = 45
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                queue_empty,
   input  logic [DATA_W-1:0]                   head_data,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [gap_pkg::AVG_W-1:0]    rsp_average,
   output logic [gap_pkg::IDX_W-1:0]           rsp_channel_index,
   output logic                                rsp_last_channel
);
   import gap_pkg::*;

   localparam int DIV_W = SUM_W + 1;

   back_state_type state_ff, state_in;

   logic signed [SUM_W-1:0] h_sum;
   logic [CNT_W-1:0]        h_sp;
   logic [IDX_W-1:0]        h_idx;
   logic                    h_last;

   logic signed [DIV_W-1:0] sum_x;
   logic [DIV_W-1:0]        mag, dividend;
   logic [DIV_W:0]          trial;

   logic [DIV_W-1:0]  rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in, last_ff, last_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic              out_valid_ff, out_valid_in;
   logic signed [AVG_W-1:0] avg_ff, avg_in, avg_sat;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic              out_last_ff, out_last_in;
   logic              out_free, load_out;

   assign {h_sum, h_sp, h_idx, h_last} = head_data;

   // Magnitude plus half the divisor, rounding half away from zero
   assign sum_x    = DIV_W'(h_sum);
   assign mag      = h_sum[SUM_W-1] ? DIV_W'(-sum_x) : DIV_W'(sum_x);
   assign dividend = mag + DIV_W'(h_sp >> 1);

   assign trial    = {1'b0, rem_ff} - {1'b0, dsh_ff};

   always_comb begin
      if (neg_ff) begin
         avg_sat = (quot_ff > NEG_LIMIT) ? AVG_MIN : AVG_W'(-quot_ff);
      end else begin
         avg_sat = (quot_ff > POS_LIMIT) ? AVG_MAX : AVG_W'(quot_ff);
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;
   assign pop      = (state_ff == ST_IDLE) && !queue_empty;
   assign load_out = (state_ff == ST_DONE) && out_free;

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               rem_in   = dividend;
               dsh_in   = DIV_W'(h_sp) << (QUOT_W - 1);
               quot_in  = '0;
               step_in  = STEP_W'(QUOT_W - 1);
               neg_in   = h_sum[SUM_W-1];
               last_in  = h_last;
               idx_in   = h_idx;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!trial[DIV_W]) begin
               rem_in  = trial[DIV_W-1:0];
               quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
            end else begin
               quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
            end
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      avg_in       = avg_ff;
      out_idx_in   = out_idx_ff;
      out_last_in  = out_last_ff;
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      if (load_out) begin
         out_valid_in = 1'b1;
         avg_in       = avg_sat;
         out_idx_in   = idx_ff;
         out_last_in  = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quot_ff     <= quot_in;
      step_ff     <= step_in;
      neg_ff      <= neg_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      avg_ff      <= avg_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_average       = avg_ff;
   assign rsp_channel_index = out_idx_ff;
   assign rsp_last_channel  = out_last_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("back-end state not one-hot");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == ST_DIV && step_ff == STEP_W'(QUOT_W - 1))
      else $error("division did not start");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> !out_valid_ff || !rsp_stall)
      else $error("result overwritten before transfer");

endmodule

/* design/global_average_pool_int8_core.sv */
// Throughput: one sample per cycle while the two-entry queue has room; channel
// results are limited by the one-bit-per-cycle serial divider, which takes the next
// channel from the queue only once it is back in its idle state.
// Reset (synchronous): clears sum, counters, queue and result valid; spatial_size
// returns to 49 and channel_count to 1280.
// Top level of the int8 global average pooling core.
`timescale 1ns / 1ps
module global_average_pool_int8_core #(
   parameter int MAX_SPATIAL  = 4096,
   parameter int CHAN_LIMIT   = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gap_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gap_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [gap_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [gap_pkg::AVG_W-1:0]    rsp_average,
   output logic [gap_pkg::IDX_W-1:0]           rsp_channel_index,
   output logic                                rsp_last_channel
);
   import gap_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SPATIAL + 1);
   localparam int SUM_W  = $clog2(MAX_SPATIAL) + SAMPLE_W;
   localparam int DATA_W = SUM_W + CNT_W + IDX_W + 1;

   logic              push_valid, queue_full, queue_empty, pop;
   logic [DATA_W-1:0] push_data, head_data;

   gap_front #(
      .MAX_SPATIAL  (MAX_SPATIAL),
      .CHAN_LIMIT   (CHAN_LIMIT),
      .CNT_W        (CNT_W),
      .SUM_W        (SUM_W),
      .DATA_W       (DATA_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   gap_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head_data  (head_data)
   );

   gap_back #(
      .CNT_W  (CNT_W),
      .SUM_W  (SUM_W),
      .DATA_W (DATA_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (queue_empty),
      .head_data         (head_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_average       (rsp_average),
      .rsp_channel_index (rsp_channel_index),
      .rsp_last_channel  (rsp_last_channel)
   );

endmodule
